@@ src/skbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package skbs_pkg;

  localparam int KEY_W          = 64;
  localparam int WORD_W         = 32;
  localparam int POS_W          = 8;
  localparam int SLOT_W         = 2;
  localparam int COUNT_W        = 9;
  localparam int REG_INDEX_W    = 2;
  localparam int LOAD_POSITIONS = 256;

  localparam int INDEX_DEPTH_DEF = 256;
  localparam int FILE_SLOTS_DEF  = 3;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_LOOKUP = 1'b1
  } command_t;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_COUNT_SLOT0 = 2'd0,
    REG_COUNT_SLOT1 = 2'd1,
    REG_COUNT_SLOT2 = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [WORD_W-1:0] data_offset;
    logic [WORD_W-1:0] packed_size;
    logic [WORD_W-1:0] unpacked_size;
  } entry_t;

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] data_offset;
    logic [WORD_W-1:0] packed_size;
    logic [WORD_W-1:0] unpacked_size;
  } result_t;

  // positions per slot that a load can reach
  function automatic int used_depth(input int index_depth);
    used_depth = (index_depth < LOAD_POSITIONS) ? index_depth : LOAD_POSITIONS;
  endfunction

endpackage

`default_nettype wire

@@ src/skbs_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

module skbs_table #(
  parameter int INDEX_DEPTH  = skbs_pkg::INDEX_DEPTH_DEF,
  parameter int FILE_SLOTS   = skbs_pkg::FILE_SLOTS_DEF,
  localparam int USED_DEPTH = skbs_pkg::used_depth(INDEX_DEPTH),
  localparam int TOTAL      = FILE_SLOTS * USED_DEPTH,
  localparam int AW         = $clog2(TOTAL)
) (
  input  wire                   clk,
  input  wire                   wr_en,
  input  wire [AW-1:0]          wr_addr,
  input  skbs_pkg::entry_t      wr_entry,
  input  wire                   rd_en,
  input  wire [AW-1:0]          rd_addr,
  output skbs_pkg::entry_t      rd_entry
);

  skbs_pkg::entry_t mem [TOTAL];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ src/skbs_search.sv @@
`timescale 1ns / 1ps
`default_nettype none

module skbs_search #(
  parameter int INDEX_DEPTH  = skbs_pkg::INDEX_DEPTH_DEF,
  parameter int FILE_SLOTS   = skbs_pkg::FILE_SLOTS_DEF,
  localparam int USED_DEPTH = skbs_pkg::used_depth(INDEX_DEPTH),
  localparam int AW         = $clog2(FILE_SLOTS * USED_DEPTH),
  localparam int PW         = $clog2(USED_DEPTH),
  localparam int BW         = PW + 1
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  input  wire                           start_slot_ok,
  input  wire [skbs_pkg::SLOT_W-1:0]    start_slot,
  input  wire [BW-1:0]                  start_count,
  input  wire [skbs_pkg::KEY_W-1:0]     start_key,
  output logic                          rd_en,
  output logic [AW-1:0]                 rd_addr,
  input  skbs_pkg::entry_t              rd_entry,
  output logic                          res_valid,
  input  wire                           res_ready,
  output skbs_pkg::result_t             res,
  output logic                          busy
);

  skbs_pkg::state_t               state, state_next;
  logic [BW-1:0]                  low_bound, high_bound;
  logic [PW-1:0]                  mid;
  logic [skbs_pkg::SLOT_W-1:0]    slot;
  logic [skbs_pkg::KEY_W-1:0]     key;

  logic [BW:0]                    mid_sum;
  logic [PW-1:0]                  mid_calc;
  logic                           window_open;
  logic                           key_lt, key_eq;

  // window is [low, high), probe at (low + high - 1) / 2
  assign mid_sum     = {1'b0, low_bound} + {1'b0, high_bound} - (BW+1)'(1);
  assign mid_calc    = mid_sum[PW:1];
  assign window_open = low_bound < high_bound;
  assign key_lt      = key < rd_entry.key;
  assign key_eq      = key == rd_entry.key;

  always_comb begin
    state_next = state;
    unique case (state)
      skbs_pkg::ST_IDLE: begin
        if (start) begin
          state_next = start_slot_ok ? skbs_pkg::ST_PROBE : skbs_pkg::ST_RESULT;
        end
      end
      skbs_pkg::ST_PROBE: begin
        state_next = window_open ? skbs_pkg::ST_COMPARE : skbs_pkg::ST_RESULT;
      end
      skbs_pkg::ST_COMPARE: begin
        state_next = key_eq ? skbs_pkg::ST_RESULT : skbs_pkg::ST_PROBE;
      end
      skbs_pkg::ST_RESULT: begin
        if (res_ready) begin
          state_next = skbs_pkg::ST_IDLE;
        end
      end
      default: state_next = skbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en     = (state == skbs_pkg::ST_PROBE) && window_open;
    rd_addr   = AW'(slot) * AW'(USED_DEPTH) + AW'(mid_calc);
    res_valid = state == skbs_pkg::ST_RESULT;
    busy      = state != skbs_pkg::ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= skbs_pkg::ST_IDLE;
      low_bound  <= '0;
      high_bound <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        skbs_pkg::ST_IDLE: begin
          if (start && start_slot_ok) begin
            low_bound  <= '0;
            high_bound <= start_count;
          end
        end
        skbs_pkg::ST_COMPARE: begin
          priority if (key_lt) begin
            high_bound <= {1'b0, mid};
          end else if (!key_eq) begin
            low_bound <= {1'b0, mid} + BW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload side: no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      skbs_pkg::ST_IDLE: begin
        if (start) begin
          slot <= start_slot;
          key  <= start_key;
          res  <= '0;
        end
      end
      skbs_pkg::ST_PROBE: begin
        mid <= mid_calc;
      end
      skbs_pkg::ST_COMPARE: begin
        if (key_eq) begin
          res.found         <= 1'b1;
          res.position      <= skbs_pkg::POS_W'(mid);
          res.data_offset   <= rd_entry.data_offset;
          res.packed_size   <= rd_entry.packed_size;
          res.unpacked_size <= rd_entry.unpacked_size;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ src/sorted_key_index_binary_search_top.sv @@
// Sorted key index with binary-search lookup, three file slots.
// Request channel (req_valid / req_stall) carries one item: command load
// writes one table entry at file_slot / position; command lookup searches
// the first entry_count_slotN entries of its slot for key.
// Result channel (rsp_valid / rsp_stall) carries one item per lookup and
// none per load; a miss returns found clear with all other fields zero.
// A load does not make the block busy, so the next item can follow at once.
// A lookup probes through the single table read port, each probe an address
// step and then a step with registered data and a 64-bit compare; a miss
// adds a step to see the window empty, and the result is then handed to the
// output register, after which the next item is taken. req_stall is high
// while a lookup is in flight.
// The result sits in an output register; while the receiver stalls it is
// held and new items are still taken, but a following lookup waits for the
// register to free up before it returns.
// Reset clears the count registers and all handshake state; table contents
// are undefined until loaded and no clearing pass runs.
// Count registers are written through wr_en / wr_index / wr_data; the user
// must do so only while the block is idle, which the block does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_index_binary_search_top #(
  parameter int INDEX_DEPTH = skbs_pkg::INDEX_DEPTH_DEF,
  parameter int FILE_SLOTS  = skbs_pkg::FILE_SLOTS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                req_valid,
  output logic                               req_stall,
  input  wire                                command,
  input  wire [skbs_pkg::SLOT_W-1:0]         file_slot,
  input  wire [skbs_pkg::KEY_W-1:0]          key,
  input  wire [skbs_pkg::POS_W-1:0]          position,
  input  wire [skbs_pkg::WORD_W-1:0]         data_offset,
  input  wire [skbs_pkg::WORD_W-1:0]         packed_size,
  input  wire [skbs_pkg::WORD_W-1:0]         unpacked_size,
  output logic                               rsp_valid,
  input  wire                                rsp_stall,
  output logic                               found,
  output logic [skbs_pkg::POS_W-1:0]         match_position,
  output logic [skbs_pkg::WORD_W-1:0]        match_offset,
  output logic [skbs_pkg::WORD_W-1:0]        match_packed_size,
  output logic [skbs_pkg::WORD_W-1:0]        match_unpacked_size,
  input  wire                                wr_en,
  input  wire [skbs_pkg::REG_INDEX_W-1:0]    wr_index,
  input  wire [skbs_pkg::COUNT_W-1:0]        wr_data
);

  localparam int USED_DEPTH = skbs_pkg::used_depth(INDEX_DEPTH);
  localparam int AW         = $clog2(FILE_SLOTS * USED_DEPTH);
  localparam int PW         = $clog2(USED_DEPTH);
  localparam int BW         = PW + 1;

  logic [skbs_pkg::COUNT_W-1:0] count0, count1, count2;
  logic [skbs_pkg::COUNT_W-1:0] count_sel, count_sat;

  logic                 accept, slot_ok, load_en, lookup_start;
  logic [AW-1:0]        wr_addr;
  skbs_pkg::entry_t     wr_entry, rd_entry;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 res_valid, res_ready, busy;
  skbs_pkg::result_t    res;

  assign req_stall    = busy;
  assign accept       = req_valid && !req_stall;
  assign slot_ok      = file_slot < skbs_pkg::SLOT_W'(FILE_SLOTS);
  assign load_en      = accept && (command == skbs_pkg::CMD_LOAD) && slot_ok
                        && ({1'b0, position} < (skbs_pkg::POS_W+1)'(USED_DEPTH));
  assign lookup_start = accept && (command == skbs_pkg::CMD_LOOKUP);

  assign wr_addr  = AW'(file_slot) * AW'(USED_DEPTH) + AW'(position[PW-1:0]);
  assign wr_entry = '{key: key, data_offset: data_offset,
                      packed_size: packed_size, unpacked_size: unpacked_size};

  always_comb begin
    unique case (file_slot)
      2'd0:    count_sel = count0;
      2'd1:    count_sel = count1;
      2'd2:    count_sel = count2;
      default: count_sel = '0;
    endcase
    count_sat = (count_sel > skbs_pkg::COUNT_W'(USED_DEPTH))
                ? skbs_pkg::COUNT_W'(USED_DEPTH) : count_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count0 <= '0;
      count1 <= '0;
      count2 <= '0;
    end else if (wr_en) begin
      unique case (skbs_pkg::reg_index_t'(wr_index))
        skbs_pkg::REG_COUNT_SLOT0: count0 <= wr_data;
        skbs_pkg::REG_COUNT_SLOT1: count1 <= wr_data;
        skbs_pkg::REG_COUNT_SLOT2: count2 <= wr_data;
        default: ;
      endcase
    end
  end

  skbs_table #(
    .INDEX_DEPTH (INDEX_DEPTH),
    .FILE_SLOTS  (FILE_SLOTS)
  ) u_table (
    .clk      (clk),
    .wr_en    (load_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  skbs_search #(
    .INDEX_DEPTH (INDEX_DEPTH),
    .FILE_SLOTS  (FILE_SLOTS)
  ) u_search (
    .clk           (clk),
    .rst           (rst),
    .start         (lookup_start),
    .start_slot_ok (slot_ok),
    .start_slot    (file_slot),
    .start_count   (count_sat[BW-1:0]),
    .start_key     (key),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_entry      (rd_entry),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .busy          (busy)
  );

  // output register frees the search as soon as it can take the item
  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      found               <= res.found;
      match_position      <= res.position;
      match_offset        <= res.data_offset;
      match_packed_size   <= res.packed_size;
      match_unpacked_size <= res.unpacked_size;
    end
  end

endmodule

`default_nettype wire

@@ src/skbs_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module skbs_checker (
  input wire                                clk,
  input wire                                rst,
  input wire                                req_valid,
  input wire                                req_stall,
  input wire                                command,
  input wire [skbs_pkg::SLOT_W-1:0]         file_slot,
  input wire [skbs_pkg::KEY_W-1:0]          key,
  input wire [skbs_pkg::POS_W-1:0]          position,
  input wire [skbs_pkg::WORD_W-1:0]         data_offset,
  input wire [skbs_pkg::WORD_W-1:0]         packed_size,
  input wire [skbs_pkg::WORD_W-1:0]         unpacked_size,
  input wire                                rsp_valid,
  input wire                                rsp_stall,
  input wire                                found,
  input wire [skbs_pkg::POS_W-1:0]          match_position,
  input wire [skbs_pkg::WORD_W-1:0]         match_offset,
  input wire [skbs_pkg::WORD_W-1:0]         match_packed_size,
  input wire [skbs_pkg::WORD_W-1:0]         match_unpacked_size,
  input wire                                wr_en,
  input wire [skbs_pkg::REG_INDEX_W-1:0]    wr_index,
  input wire [skbs_pkg::COUNT_W-1:0]        wr_data
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(found)
      && $stable(match_position) && $stable(match_offset))
    else $error("result changed while stalled");

  // a miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> match_position == '0 && match_offset == '0
      && match_packed_size == '0 && match_unpacked_size == '0)
    else $error("miss with nonzero fields");

  // an accepted lookup always makes the search busy and raises req_stall
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && command == skbs_pkg::CMD_LOOKUP |=> req_stall)
    else $error("lookup accepted without going busy");

  // a load never produces a result right away from an idle block
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && command == skbs_pkg::CMD_LOAD && !rsp_valid
      |=> !rsp_valid)
    else $error("load produced a result");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("handshake not cleared by reset");

endmodule

bind sorted_key_index_binary_search_top skbs_checker u_skbs_checker (.*);

`default_nettype wire

@@ sim/skbs_checker.sv @@
`timescale 1ns / 1ps

module skbs_scoreboard (
  input  wire                                       clk,
  input  wire                                       rst,
  input  wire                                       req_valid,
  input  wire                                       req_stall,
  input  wire                                       command,
  input  wire [skbs_pkg::SLOT_W-1:0]                file_slot,
  input  wire [skbs_pkg::KEY_W-1:0]                 key,
  input  wire [skbs_pkg::POS_W-1:0]                 position,
  input  wire [skbs_pkg::WORD_W-1:0]                data_offset,
  input  wire [skbs_pkg::WORD_W-1:0]                packed_size,
  input  wire [skbs_pkg::WORD_W-1:0]                unpacked_size,
  input  wire                                       rsp_valid,
  input  wire                                       rsp_stall,
  input  wire                                       found,
  input  wire [skbs_pkg::POS_W-1:0]                 match_position,
  input  wire [skbs_pkg::WORD_W-1:0]                match_offset,
  input  wire [skbs_pkg::WORD_W-1:0]                match_packed_size,
  input  wire [skbs_pkg::WORD_W-1:0]                match_unpacked_size,
  input  wire                                       wr_en,
  input  wire [skbs_pkg::REG_INDEX_W-1:0]           wr_index,
  input  wire [skbs_pkg::COUNT_W-1:0]               wr_data,
  output int                                        mismatches,
  output int                                        waiting,
  output int                                        lookups,
  output int                                        hits
);

  localparam int DEPTH = skbs_pkg::INDEX_DEPTH_DEF;
  localparam int SLOTS = skbs_pkg::FILE_SLOTS_DEF;

  logic [skbs_pkg::KEY_W-1:0]   key_tbl      [SLOTS][DEPTH];
  logic [skbs_pkg::WORD_W-1:0]  offset_tbl   [SLOTS][DEPTH];
  logic [skbs_pkg::WORD_W-1:0]  packed_tbl   [SLOTS][DEPTH];
  logic [skbs_pkg::WORD_W-1:0]  unpacked_tbl [SLOTS][DEPTH];
  logic [skbs_pkg::COUNT_W-1:0] slot_count   [SLOTS];

  skbs_pkg::result_t lookup_results_q [$];
  int mismatch_total;
  int lookup_total;
  int hit_total;

  // binary search over the first count entries, stopping at the first equal probe
  function automatic skbs_pkg::result_t find_key(input logic [skbs_pkg::SLOT_W-1:0] slot,
                                                 input logic [skbs_pkg::KEY_W-1:0] k);
    skbs_pkg::result_t r;
    int lo;
    int hi;
    int mid;
    r = '0;
    if (slot < SLOTS) begin
      lo = 0;
      hi = (slot_count[slot] > DEPTH) ? DEPTH : slot_count[slot];
      if (hi > skbs_pkg::LOAD_POSITIONS) hi = skbs_pkg::LOAD_POSITIONS;
      while (lo < hi) begin
        mid = (lo + hi - 1) / 2;
        if (k < key_tbl[slot][mid]) begin
          hi = mid;
        end else if (k > key_tbl[slot][mid]) begin
          lo = mid + 1;
        end else begin
          r.found         = 1'b1;
          r.position      = mid[skbs_pkg::POS_W-1:0];
          r.data_offset   = offset_tbl[slot][mid];
          r.packed_size   = packed_tbl[slot][mid];
          r.unpacked_size = unpacked_tbl[slot][mid];
          lo = hi;
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(input string what, input logic [skbs_pkg::KEY_W-1:0] want,
                             input logic [skbs_pkg::KEY_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, what, want, got);
      mismatch_total++;
    end
  endtask

  always @(posedge clk) begin : watch
    skbs_pkg::result_t want;
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) slot_count[s] = '0;
      lookup_results_q.delete();
      mismatch_total = 0;
      lookup_total = 0;
      hit_total = 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          skbs_pkg::REG_COUNT_SLOT0: slot_count[0] = wr_data;
          skbs_pkg::REG_COUNT_SLOT1: slot_count[1] = wr_data;
          skbs_pkg::REG_COUNT_SLOT2: slot_count[2] = wr_data;
          default: ;
        endcase
      end

      // results first, so a lookup taken on this edge cannot claim this item
      if (rsp_valid && !rsp_stall) begin
        if (lookup_results_q.size() == 0) begin
          $display("%0t: expected no result, got found %b position %0d offset %h",
                   $time, found, match_position, match_offset);
          mismatch_total++;
        end else begin
          want = lookup_results_q.pop_front();
          check_field("found", want.found, found);
          check_field("match_position", want.position, match_position);
          check_field("match_offset", want.data_offset, match_offset);
          check_field("match_packed_size", want.packed_size, match_packed_size);
          check_field("match_unpacked_size", want.unpacked_size, match_unpacked_size);
        end
      end

      if (req_valid && !req_stall) begin
        if (command == skbs_pkg::CMD_LOAD) begin
          if (file_slot < SLOTS && position < DEPTH) begin
            key_tbl[file_slot][position]      = key;
            offset_tbl[file_slot][position]   = data_offset;
            packed_tbl[file_slot][position]   = packed_size;
            unpacked_tbl[file_slot][position] = unpacked_size;
          end
        end else begin
          want = find_key(file_slot, key);
          lookup_results_q.push_back(want);
          lookup_total++;
          if (want.found) hit_total++;
        end
      end
    end
    mismatches <= mismatch_total;
    waiting    <= lookup_results_q.size();
    lookups    <= lookup_total;
    hits       <= hit_total;
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int ITEM_TARGET = 1250;
  localparam int HOLD_CYCLES = 25;
  localparam int SLOTS       = skbs_pkg::FILE_SLOTS_DEF;
  localparam int DEPTH       = skbs_pkg::INDEX_DEPTH_DEF;
  localparam logic [skbs_pkg::SLOT_W-1:0]      SLOT_UNUSED = 2'd3;
  localparam logic [skbs_pkg::REG_INDEX_W-1:0] REG_BEYOND  = 2'd3;

  typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY} flow_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             req_valid = 1'b0;
  logic                             req_stall;
  logic                             command = skbs_pkg::CMD_LOAD;
  logic [skbs_pkg::SLOT_W-1:0]      file_slot = '0;
  logic [skbs_pkg::KEY_W-1:0]       key = '0;
  logic [skbs_pkg::POS_W-1:0]       position = '0;
  logic [skbs_pkg::WORD_W-1:0]      data_offset = '0;
  logic [skbs_pkg::WORD_W-1:0]      packed_size = '0;
  logic [skbs_pkg::WORD_W-1:0]      unpacked_size = '0;
  logic                             rsp_valid;
  logic                             rsp_stall = 1'b0;
  logic                             found;
  logic [skbs_pkg::POS_W-1:0]       match_position;
  logic [skbs_pkg::WORD_W-1:0]      match_offset;
  logic [skbs_pkg::WORD_W-1:0]      match_packed_size;
  logic [skbs_pkg::WORD_W-1:0]      match_unpacked_size;
  logic                             wr_en = 1'b0;
  logic [skbs_pkg::REG_INDEX_W-1:0] wr_index = skbs_pkg::REG_COUNT_SLOT0;
  logic [skbs_pkg::COUNT_W-1:0]     wr_data = '0;

  int mismatches;
  int waiting;
  int lookups;
  int hits;

  // what the stimulus knows about the tables, used to aim lookups at real keys
  logic [skbs_pkg::KEY_W-1:0]   shadow_key     [SLOTS][DEPTH];
  bit                           shadow_written [SLOTS][DEPTH];
  int                           tbl_len        [SLOTS];
  logic [skbs_pkg::COUNT_W-1:0] cur_count      [SLOTS];

  int    items_sent = 0;
  int    burst_left = 0;
  int    stall_span = 0;
  flow_t stall_mode = FLOW_FREE;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_key_index_binary_search_top uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .command(command), .file_slot(file_slot), .key(key), .position(position),
    .data_offset(data_offset), .packed_size(packed_size), .unpacked_size(unpacked_size),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .found(found), .match_position(match_position), .match_offset(match_offset),
    .match_packed_size(match_packed_size), .match_unpacked_size(match_unpacked_size),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  skbs_scoreboard u_scoreboard (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .command(command), .file_slot(file_slot), .key(key), .position(position),
    .data_offset(data_offset), .packed_size(packed_size), .unpacked_size(unpacked_size),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .found(found), .match_position(match_position), .match_offset(match_offset),
    .match_packed_size(match_packed_size), .match_unpacked_size(match_unpacked_size),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .mismatches(mismatches), .waiting(waiting), .lookups(lookups), .hits(hits)
  );

  // receiver: stretches of free flow, light stalling and heavy stalling
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = flow_t'($urandom_range(0, 2));
      stall_span = $urandom_range(10, 150);
    end
    stall_span--;
    case (stall_mode)
      FLOW_FREE:  rsp_stall <= 1'b0;
      FLOW_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
      default:    rsp_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  function automatic logic [skbs_pkg::KEY_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int written_prefix(input int s);
    int p;
    p = 0;
    while (p < DEPTH && shadow_written[s][p]) p++;
    return p;
  endfunction

  // count stays within the written part of a slot, or goes above the depth once the slot is fully written
  function automatic logic [skbs_pkg::COUNT_W-1:0] pick_count(input int s);
    int p;
    int r;
    p = written_prefix(s);
    r = $urandom_range(0, 99);
    if (r < 60) return skbs_pkg::COUNT_W'(tbl_len[s]);
    if (r < 75) return skbs_pkg::COUNT_W'($urandom_range(0, tbl_len[s]));
    if (r < 85) return skbs_pkg::COUNT_W'(p);
    if (r < 93) return '0;
    if (p == DEPTH) return skbs_pkg::COUNT_W'($urandom_range(DEPTH + 1, 511));
    return skbs_pkg::COUNT_W'(p);
  endfunction

  task automatic issue_item(input logic cmd, input logic [skbs_pkg::SLOT_W-1:0] slot,
                            input logic [skbs_pkg::KEY_W-1:0] k,
                            input logic [skbs_pkg::POS_W-1:0] pos,
                            input logic [skbs_pkg::WORD_W-1:0] off,
                            input logic [skbs_pkg::WORD_W-1:0] psz,
                            input logic [skbs_pkg::WORD_W-1:0] usz);
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    req_valid     <= 1'b1;
    command       <= cmd;
    file_slot     <= slot;
    key           <= k;
    position      <= pos;
    data_offset   <= off;
    packed_size   <= psz;
    unpacked_size <= usz;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    burst_left--;
    if (cmd == skbs_pkg::CMD_LOAD && slot < SLOTS) begin
      shadow_key[slot][pos]     = k;
      shadow_written[slot][pos] = 1'b1;
    end
    if (!(cmd == skbs_pkg::CMD_LOAD && slot >= SLOTS)) items_sent++;
  endtask

  // stop sending until every lookup has returned; hold covers a trailing load
  task automatic settle(input bit hold);
    req_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    if (hold) repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic write_counts(input logic [skbs_pkg::COUNT_W-1:0] c0,
                              input logic [skbs_pkg::COUNT_W-1:0] c1,
                              input logic [skbs_pkg::COUNT_W-1:0] c2);
    cur_count[0] = c0;
    cur_count[1] = c1;
    cur_count[2] = c2;
    wr_en    <= 1'b1;
    wr_index <= skbs_pkg::REG_COUNT_SLOT0;
    wr_data  <= c0;
    @(posedge clk);
    wr_index <= skbs_pkg::REG_COUNT_SLOT1;
    wr_data  <= c1;
    @(posedge clk);
    wr_index <= skbs_pkg::REG_COUNT_SLOT2;
    wr_data  <= c2;
    @(posedge clk);
    // an index past the count registers must not disturb anything
    wr_index <= REG_BEYOND;
    wr_data  <= ($urandom_range(0, 1) == 0) ? 9'h1FF : 9'($urandom);
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // ascending keys with occasional duplicates and NUL-padded tails
  task automatic load_sorted_table(input int s, input int n);
    logic [skbs_pkg::KEY_W-1:0] run [DEPTH];
    logic [skbs_pkg::KEY_W-1:0] span;
    logic [skbs_pkg::KEY_W-1:0] k;
    logic [skbs_pkg::KEY_W-1:0] pad_mask;
    bit                         down;
    int                         i;
    int                         p;
    span     = 64'hFFFF_FFFF_FFFF_FFFF / (n + 1);
    k        = rand64() % span;
    pad_mask = ~64'h0 << (8 * $urandom_range(0, 7));
    down     = 1'($urandom_range(0, 1));
    for (i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 15) != 0) k = k + 1 + rand64() % span;
      run[i] = k & pad_mask;
    end
    for (i = 0; i < n; i++) begin
      p = down ? n - 1 - i : i;
      issue_item(skbs_pkg::CMD_LOAD, skbs_pkg::SLOT_W'(s), run[p], skbs_pkg::POS_W'(p),
                 $urandom, $urandom, $urandom);
    end
    tbl_len[s] = n;
  endtask

  task automatic random_item();
    int                          s;
    int                          usable;
    int                          r;
    logic                        cmd;
    logic [skbs_pkg::SLOT_W-1:0] slot;
    logic [skbs_pkg::KEY_W-1:0]  k;
    s      = $urandom_range(0, SLOTS - 1);
    usable = (cur_count[s] > DEPTH) ? DEPTH : cur_count[s];
    r      = $urandom_range(0, 99);
    cmd    = skbs_pkg::CMD_LOOKUP;
    slot   = skbs_pkg::SLOT_W'(s);
    k      = rand64();
    if (r < 50 && usable > 0) begin
      k = shadow_key[s][$urandom_range(0, usable - 1)];
    end else if (r < 72 && usable > 0) begin
      // just beside a stored key
      k = shadow_key[s][$urandom_range(0, usable - 1)];
      k = ($urandom_range(0, 1) == 0) ? k + 1 : k - 1;
    end else if (r < 80) begin
      slot = SLOT_UNUSED;
    end else if (r < 86) begin
      cmd  = skbs_pkg::CMD_LOAD;
      slot = skbs_pkg::SLOT_W'($urandom_range(0, SLOTS));
    end else if (r < 94) begin
      k = ($urandom_range(0, 1) == 0) ? '0 : '1;
    end
    issue_item(cmd, slot, k, skbs_pkg::POS_W'($urandom_range(0, 255)),
               $urandom, $urandom, $urandom);
  endtask

  initial begin : stimulus
    int phase;
    int s;
    int n;
    logic [skbs_pkg::COUNT_W-1:0] c [SLOTS];
    tbl_len   = '{0, 0, 0};
    cur_count = '{'0, '0, '0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty tables with all counts zero, and the unused slot
    issue_item(skbs_pkg::CMD_LOOKUP, 2'd0, '0, '0, '0, '0, '0);
    issue_item(skbs_pkg::CMD_LOOKUP, SLOT_UNUSED, '1, 8'hFF, '1, '1, '1);
    issue_item(skbs_pkg::CMD_LOAD, SLOT_UNUSED, 64'h1234, '0, '1, '1, '1);
    issue_item(skbs_pkg::CMD_LOAD, 2'd0, '0, '0, '0, '0, '0);
    issue_item(skbs_pkg::CMD_LOAD, 2'd0, 64'h4100_0000_0000_0000, 8'd1, '1, '0, '1);
    issue_item(skbs_pkg::CMD_LOAD, 2'd0, 64'h4100_0000_0000_0000, 8'd2,
               32'd1, 32'd2, 32'd3);
    issue_item(skbs_pkg::CMD_LOAD, 2'd0, 64'h4142_4300_0000_0000, 8'd3,
               $urandom, $urandom, $urandom);
    issue_item(skbs_pkg::CMD_LOAD, 2'd0, '1, 8'd4, '1, '1, '1);
    issue_item(skbs_pkg::CMD_LOAD, 2'd1, 64'h8000_0000_0000_0000, '0,
               $urandom, $urandom, $urandom);
    issue_item(skbs_pkg::CMD_LOAD, 2'd2, 64'h7FFF_FFFF_FFFF_FFFF, 8'hFF, '1, '0, '1);
    settle(1'b1);
    tbl_len[0] = 5;
    tbl_len[1] = 1;
    write_counts(9'd5, 9'd1, 9'd0);

    // first probe lands on the second of the duplicate pair
    issue_item(skbs_pkg::CMD_LOOKUP, 2'd0, 64'h4100_0000_0000_0000, '0, '0, '0, '0);
    issue_item(skbs_pkg::CMD_LOOKUP, 2'd0, '0, '0, '0, '0, '0);
    issue_item(skbs_pkg::CMD_LOOKUP, 2'd0, 64'h4142_4300_0000_0000, '0, '0, '0, '0);
    issue_item(skbs_pkg::CMD_LOOKUP, 2'd0, '1, '0, '0, '0, '0);
    issue_item(skbs_pkg::CMD_LOOKUP, 2'd0, 64'h4100_0000_0000_0001, '0, '0, '0, '0);
    issue_item(skbs_pkg::CMD_LOOKUP, 2'd0, 64'h1, '0, '0, '0, '0);
    issue_item(skbs_pkg::CMD_LOOKUP, 2'd1, 64'h8000_0000_0000_0000, '0, '0, '0, '0);
    issue_item(skbs_pkg::CMD_LOOKUP, 2'd1, '0, '0, '0, '0, '0);
    issue_item(skbs_pkg::CMD_LOOKUP, 2'd1, '1, '0, '0, '0, '0);
    issue_item(skbs_pkg::CMD_LOOKUP, 2'd2, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0, '0, '0);
    issue_item(skbs_pkg::CMD_LOOKUP, SLOT_UNUSED, '0, '0, '0, '0, '0);
    settle(1'b1);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      for (s = 0; s < SLOTS; s++) begin
        if ((phase == 0 && s == 0) || (phase == 3 && s == 2)) n = DEPTH;
        else if ($urandom_range(0, 3) == 0) n = 0;
        else n = $urandom_range(1, 24);
        if (n > 0) load_sorted_table(s, n);
      end
      settle(1'b1);
      for (s = 0; s < SLOTS; s++) c[s] = pick_count(s);
      // full-depth and saturated counts at least once
      if (phase == 0) c[0] = skbs_pkg::COUNT_W'(DEPTH);
      if (phase == 1) c[0] = 9'h1FF;
      if (phase == 3) c[2] = skbs_pkg::COUNT_W'(DEPTH + 1);
      write_counts(c[0], c[1], c[2]);
      repeat ($urandom_range(60, 120)) begin
        random_item();
        if ($urandom_range(0, 49) == 0) settle(1'b0);
      end
      settle(1'b1);
      phase++;
    end

    $display("Sent %0d items over %0d table settings: %0d lookups, %0d of them hits",
             items_sent, phase + 1, lookups, hits);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
